@@ design/dtq_pkg.sv @@
// Package for the deadline timer queue: command and status codes, back-end states, queue entry type.
// No dependencies.
package dtq_pkg;

  localparam int unsigned NumTimersDefault = 16;
  localparam int unsigned MaxFire          = 16;
  localparam logic [31:0] NoDeadline       = 32'hFFFF_FFFF;
  localparam logic [31:0] MaxTimeoutReset  = 32'hFFFF_FFFE;

  typedef enum logic [2:0] {
    CmdCreate  = 3'd0,
    CmdSet     = 3'd1,
    CmdSetOne  = 3'd2,
    CmdCancel  = 3'd3,
    CmdDestroy = 3'd4,
    CmdPoll    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StInvalid  = 3'd1,
    StTooLarge = 3'd2,
    StFull     = 3'd3,
    StOverflow = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkExec,
    BkScan,
    BkFire,
    BkFinal
  } bk_state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  handle;
    logic [31:0] timeout;
    logic [31:0] user_data;
    logic [63:0] now64;
    logic        too_large;
  } item_t;

endpackage

@@ design/dtq_front.sv @@
// Front end: widens the tick count, checks the timeout, pushes items into a
// two-entry queue. Depends on dtq_pkg.
module dtq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [2:0]           command_i,
  input  logic [3:0]           handle_i,
  input  logic [31:0]          timeout_i,
  input  logic [31:0]          user_data_i,
  input  logic [31:0]          now_count_i,
  input  logic [31:0]          max_timeout_i,
  input  logic                 pop_i,
  output logic                 avail_o,
  output dtq_pkg::item_t       item_o
);

  logic [31:0]    tick_high_q, tick_high_d, tick_low_q;
  dtq_pkg::item_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push;
  dtq_pkg::item_t new_item;

  assign busy_o  = (cnt_q == 2'd2);
  assign push    = start_i && !busy_o;
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    tick_high_d = tick_high_q + ((now_count_i < tick_low_q) ? 32'd1 : 32'd0);
    new_item.command   = command_i;
    new_item.handle    = handle_i;
    new_item.timeout   = timeout_i;
    new_item.user_data = user_data_i;
    new_item.now64     = {tick_high_d, now_count_i};
    new_item.too_large = (timeout_i > max_timeout_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_high_q <= '0;
      tick_low_q  <= '0;
      wr_q        <= 1'b0;
      rd_q        <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (push) begin
        tick_high_q <= tick_high_d;
        tick_low_q  <= now_count_i;
        wr_q        <= ~wr_q;
      end
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= new_item;
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop_i) |=> busy_o) else $error("full queue not busy");
`endif

endmodule

@@ design/dtq_back.sv @@
// Back end: timer table, command execution and the sequential poll scan.
// Depends on dtq_pkg.
module dtq_back #(
  parameter int unsigned NumTimers = dtq_pkg::NumTimersDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avail_i,
  input  dtq_pkg::item_t       item_i,
  output logic                 pop_o,
  output logic                 valid_o,
  output logic [2:0]           status_o,
  output logic [3:0]           result_handle_o,
  output logic                 was_pending_o,
  output logic                 fired_o,
  output logic [31:0]          fired_data_o,
  output logic [31:0]          next_timeout_o,
  output logic                 last_o
);

  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned CntW = $clog2(NumTimers + 1);
  localparam int unsigned FireW = $clog2(dtq_pkg::MaxFire + 1);

  logic [63:0] deadline_q [NumTimers];
  logic [31:0] order_q    [NumTimers];
  logic [31:0] data_q     [NumTimers];
  logic [NumTimers-1:0] alloc_q, pend_q, one_q;
  logic [31:0] arm_cnt_q;

  dtq_pkg::bk_state_e state_q, state_d;
  dtq_pkg::item_t     cur_q;
  logic [CntW-1:0]    scan_q;
  logic [FireW-1:0]   fire_q;
  logic               found_q;
  logic [IdxW-1:0]    best_q;
  logic [63:0]        best_dl_q;
  logic [31:0]        best_ord_q;

  logic               valid_d, wp_d, fired_d, last_d;
  logic [2:0]         status_d;
  logic [3:0]         rh_d;
  logic [31:0]        fd_d, nt_d;

  logic [IdxW-1:0]    sidx, hidx, free_idx;
  logic               free_found, hvalid;
  logic [63:0]        dl_sum;
  logic               dl_ovf;
  logic [63:0]        diff;

  assign sidx = scan_q[IdxW-1:0];
  assign hidx = IdxW'(cur_q.handle);
  assign {dl_ovf, dl_sum} = {1'b0, cur_q.now64} + {33'd0, cur_q.timeout};
  assign diff = best_dl_q - cur_q.now64;
  assign pop_o = (state_q == dtq_pkg::BkIdle) && avail_i;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    hvalid = ({28'd0, cur_q.handle} < 32'(NumTimers)) && alloc_q[hidx] && !one_q[hidx];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtq_pkg::BkIdle:  if (avail_i) state_d = dtq_pkg::BkExec;
      dtq_pkg::BkExec:  state_d = (cur_q.command == dtq_pkg::CmdPoll) ?
                                  dtq_pkg::BkScan : dtq_pkg::BkIdle;
      dtq_pkg::BkScan:  if (scan_q == CntW'(NumTimers - 1)) state_d = dtq_pkg::BkFire;
      dtq_pkg::BkFire:  state_d = (found_q && best_dl_q <= cur_q.now64 &&
                                   fire_q != FireW'(dtq_pkg::MaxFire)) ?
                                  dtq_pkg::BkScan : dtq_pkg::BkIdle;
      default:          state_d = dtq_pkg::BkIdle;
    endcase
  end

  always_comb begin
    valid_d = 1'b0; status_d = dtq_pkg::StOk; rh_d = '0; wp_d = 1'b0;
    fired_d = 1'b0; fd_d = '0; nt_d = '0; last_d = 1'b1;
    unique case (state_q)
      dtq_pkg::BkExec: begin
        if (cur_q.command != dtq_pkg::CmdPoll) valid_d = 1'b1;
        priority case (cur_q.command)
          dtq_pkg::CmdCreate: begin
            if (!free_found) status_d = dtq_pkg::StFull;
            else rh_d = 4'(free_idx);
          end
          dtq_pkg::CmdSet: begin
            rh_d = cur_q.handle;
            if (cur_q.too_large) status_d = dtq_pkg::StTooLarge;
            else if (!hvalid) status_d = dtq_pkg::StInvalid;
            else begin
              wp_d = pend_q[hidx];
              if (dl_ovf) status_d = dtq_pkg::StOverflow;
            end
          end
          dtq_pkg::CmdSetOne: begin
            if (cur_q.too_large) status_d = dtq_pkg::StTooLarge;
            else if (!free_found) status_d = dtq_pkg::StFull;
            else if (dl_ovf) status_d = dtq_pkg::StOverflow;
            else rh_d = 4'(free_idx);
          end
          dtq_pkg::CmdCancel, dtq_pkg::CmdDestroy: begin
            rh_d = cur_q.handle;
            if (!hvalid) status_d = dtq_pkg::StInvalid;
            else wp_d = pend_q[hidx];
          end
          default: ;
        endcase
      end
      dtq_pkg::BkFire: begin
        valid_d = 1'b1;
        if (found_q && best_dl_q <= cur_q.now64 &&
            fire_q != FireW'(dtq_pkg::MaxFire)) begin
          rh_d = 4'(best_q); fired_d = 1'b1; fd_d = data_q[best_q]; last_d = 1'b0;
        end else if (!found_q) nt_d = dtq_pkg::NoDeadline;
        else nt_d = (diff > 64'hFFFF_FFFE) ? 32'd0 : diff[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dtq_pkg::BkIdle;
      alloc_q   <= '0;
      pend_q    <= '0;
      one_q     <= '0;
      arm_cnt_q <= '0;
      valid_o   <= 1'b0;
      scan_q    <= '0;
      fire_q    <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= valid_d;
      unique case (state_q)
        dtq_pkg::BkIdle: begin
          fire_q <= '0;
        end
        dtq_pkg::BkExec: begin
          scan_q <= '0; found_q <= 1'b0;
          priority case (cur_q.command)
            dtq_pkg::CmdCreate: if (free_found) begin
              alloc_q[free_idx] <= 1'b1; pend_q[free_idx] <= 1'b0;
              one_q[free_idx] <= 1'b0;
            end
            dtq_pkg::CmdSet: if (!cur_q.too_large && hvalid) begin
              pend_q[hidx] <= !dl_ovf;
              if (!dl_ovf) arm_cnt_q <= arm_cnt_q + 32'd1;
            end
            dtq_pkg::CmdSetOne: if (!cur_q.too_large && free_found && !dl_ovf) begin
              alloc_q[free_idx] <= 1'b1; one_q[free_idx] <= 1'b1;
              pend_q[free_idx] <= 1'b1; arm_cnt_q <= arm_cnt_q + 32'd1;
            end
            dtq_pkg::CmdCancel, dtq_pkg::CmdDestroy: if (hvalid) begin
              pend_q[hidx] <= 1'b0;
              if (cur_q.command == dtq_pkg::CmdDestroy)
                alloc_q[hidx] <= 1'b0;
            end
            default: ;
          endcase
        end
        dtq_pkg::BkScan: begin
          scan_q <= scan_q + CntW'(1);
          if (pend_q[sidx] && (!found_q || deadline_q[sidx] < best_dl_q ||
              (deadline_q[sidx] == best_dl_q && order_q[sidx] < best_ord_q))) begin
            found_q <= 1'b1;
          end
        end
        dtq_pkg::BkFire: begin
          scan_q <= '0; found_q <= 1'b0;
          if (fired_d) begin
            fire_q <= fire_q + FireW'(1);
            pend_q[best_q] <= 1'b0;
            if (one_q[best_q]) begin
              alloc_q[best_q] <= 1'b0; one_q[best_q] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
    status_o <= status_d; result_handle_o <= rh_d; was_pending_o <= wp_d;
    fired_o <= fired_d; fired_data_o <= fd_d; next_timeout_o <= nt_d; last_o <= last_d;
    if (state_q == dtq_pkg::BkScan && pend_q[sidx] && (!found_q ||
        deadline_q[sidx] < best_dl_q ||
        (deadline_q[sidx] == best_dl_q && order_q[sidx] < best_ord_q))) begin
      best_q <= sidx; best_dl_q <= deadline_q[sidx]; best_ord_q <= order_q[sidx];
    end
    if (state_q == dtq_pkg::BkExec) begin
      if (cur_q.command == dtq_pkg::CmdSet && !cur_q.too_large && hvalid) begin
        data_q[hidx]     <= cur_q.user_data;
        deadline_q[hidx] <= dl_sum;
        order_q[hidx]    <= arm_cnt_q;
      end
      if (cur_q.command == dtq_pkg::CmdSetOne && !cur_q.too_large && free_found) begin
        data_q[free_idx] <= cur_q.user_data;
        deadline_q[free_idx] <= dl_sum;
        order_q[free_idx] <= arm_cnt_q;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (one_q & ~alloc_q) == '0) else $error("one-shot entry not allocated");
  a_pend_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & ~alloc_q) == '0) else $error("pending entry not allocated");
  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_q <= FireW'(dtq_pkg::MaxFire)) else $error("fire count beyond limit");
`endif

endmodule

@@ design/deadline_timer_queue.sv @@
// Top level of the deadline timer queue: front end, item queue, back end and
// the max_timeout register. Depends on dtq_pkg, dtq_front, dtq_back.
//
// Commands are taken when start is high and busy low; a two-entry queue
// lets two commands wait behind the one in progress. With the back end idle,
// a non-poll command passes through the queue into the back end, is executed
// there and has its result strobe registered onto valid_o. A poll scans the
// table one entry a cycle; each fired timer, and then the final result, takes a
// full scan of the table and a fire step, up to the fire limit. Results
// appear for one cycle on valid_o and must be taken then; the receiver cannot stall.
module deadline_timer_queue #(
  parameter int unsigned NUM_TIMERS = dtq_pkg::NumTimersDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [3:0]  handle_i,
  input  logic [31:0] timeout_i,
  input  logic [31:0] user_data_i,
  input  logic [31:0] now_count_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [3:0]  result_handle_o,
  output logic        was_pending_o,
  output logic        fired_o,
  output logic [31:0] fired_data_o,
  output logic [31:0] next_timeout_o,
  output logic        last_o
);

  logic [31:0]    max_timeout_q;
  logic           pop, avail;
  dtq_pkg::item_t item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_timeout_q <= dtq_pkg::MaxTimeoutReset;
    else if (cfg_valid_i) max_timeout_q <= cfg_data_i;
  end

  dtq_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .command_i, .handle_i,
    .timeout_i, .user_data_i, .now_count_i, .max_timeout_i(max_timeout_q),
    .pop_i(pop), .avail_o(avail), .item_o(item)
  );

  dtq_back #(.NumTimers(NUM_TIMERS)) u_back (
    .clk_i, .rst_ni, .avail_i(avail), .item_i(item), .pop_o(pop), .valid_o,
    .status_o, .result_handle_o, .was_pending_o, .fired_o, .fired_data_o,
    .next_timeout_o, .last_o
  );

endmodule
